[rtl/vgpm_pkg.sv]
// Package with field widths, register indexes and constants of the voice gain/pan/mix block.
`timescale 1ns / 1ps
`default_nettype none
package vgpm_pkg;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MASTER_VOLUME    = 2'd0;
    localparam cfg_idx_t CFG_FX_MIX_MAJOR     = 2'd1;
    localparam cfg_idx_t CFG_FX_MIX_SCALE     = 2'd2;
    localparam cfg_idx_t CFG_GAIN_CHANGE_TIME = 2'd3;

    localparam logic [14:0] MASTER_VOLUME_RST    = 15'd32767;
    localparam logic [7:0]  FX_MIX_MAJOR_RST     = 8'd0;
    localparam logic [7:0]  FX_MIX_SCALE_RST     = 8'd1;
    localparam logic [30:0] GAIN_CHANGE_TIME_RST = 31'd1000;

    localparam logic [7:0] FADE_NONE      = 8'hff;
    localparam logic [7:0] PAN_CENTER     = 8'd64;
    localparam logic [7:0] PAN_MAX        = 8'd127;
    localparam logic [6:0] MIX_MAJOR_MULT = 7'd127;
    localparam logic [6:0] MIX_MAX        = 7'd127;

endpackage
`default_nettype wire

[rtl/voice_gain_pan_mix_calc_top.sv]
// Voice gain, effects mix, pan and envelope time calculator, four-stage pipeline.
// Each accepted transaction describes one voice and yields exactly one result transaction
// through the four register stages. A new one can be taken every cycle unless backpressure
// has filled every stage; the stages follow the chain of products behind the volume (velocity
// and tremolo, then envelope gain and master volume, then the fade scale, then the final 24 x
// 17 bit product), one step per stage. Backpressure on m_tready stalls the pipeline without
// losing or repeating anything; empty stages still fill while the output waits. Configuration
// writes are always taken and should only happen while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module voice_gain_pan_mix_calc_top (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // tremolo_level[7:0], note_velocity[14:8], envelope_gain[29:15], sample_volume[37:30],
    // channel_volume[45:38], fade_level[53:46], channel_fx_mix[61:54], channel_pan[68:62],
    // sample_pan[75:69], envelope_end_time[107:76], now_time[139:108], zero pad [143:140]
    input  wire  [vgpm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // voice_volume[15:0], voice_fx_mix[23:16], voice_pan[30:24],
    // envelope_remaining[61:31], zero pad [63:62]
    output logic [vgpm_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [vgpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [vgpm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vgpm_pkg::*;

    // configuration
    logic [14:0] master_volume_reg;
    logic [7:0]  fx_mix_major_reg;
    logic [7:0]  fx_mix_scale_reg;
    logic [30:0] gain_change_time_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_volume_reg    <= MASTER_VOLUME_RST;
            fx_mix_major_reg     <= FX_MIX_MAJOR_RST;
            fx_mix_scale_reg     <= FX_MIX_SCALE_RST;
            gain_change_time_reg <= GAIN_CHANGE_TIME_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MASTER_VOLUME:    master_volume_reg    <= cfg_data[14:0];
                CFG_FX_MIX_MAJOR:     fx_mix_major_reg     <= cfg_data[7:0];
                CFG_FX_MIX_SCALE:     fx_mix_scale_reg     <= cfg_data[7:0];
                CFG_GAIN_CHANGE_TIME: gain_change_time_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // input unpack
    logic [7:0]  in_trem;
    logic [6:0]  in_vel;
    logic [14:0] in_eg;
    logic [7:0]  in_svol;
    logic [7:0]  in_cvol;
    logic [7:0]  in_fade;
    logic [7:0]  in_fx;
    logic [6:0]  in_cpan;
    logic [6:0]  in_span;
    logic [31:0] in_end;
    logic [31:0] in_now;

    assign in_trem = s_tdata[7:0];
    assign in_vel  = s_tdata[14:8];
    assign in_eg   = s_tdata[29:15];
    assign in_svol = s_tdata[37:30];
    assign in_cvol = s_tdata[45:38];
    assign in_fade = s_tdata[53:46];
    assign in_fx   = s_tdata[61:54];
    assign in_cpan = s_tdata[68:62];
    assign in_span = s_tdata[75:69];
    assign in_end  = s_tdata[107:76];
    assign in_now  = s_tdata[139:108];

    // handshake through the stages
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: first products, mix sum, pan, time left
    logic [14:0] tv1_reg;
    logic [15:0] sc1_reg;
    logic [14:0] eg1_reg;
    logic [7:0]  fade1_reg;
    logic [15:0] mixsum1_reg;
    logic        flag1_reg;
    logic [6:0]  pan1_reg;
    logic [30:0] rem1_reg;

    logic [15:0] mixsum1_next;
    logic [7:0]  psum;
    logic [7:0]  poff;
    logic [6:0]  pan1_next;
    logic [31:0] diff;
    logic [30:0] rem1_next;

    always_comb begin
        mixsum1_next = {9'd0, in_fx[6:0]} + 16'(fx_mix_major_reg * MIX_MAJOR_MULT);
        psum = {1'b0, in_cpan} + {1'b0, in_span};
        poff = psum - PAN_CENTER;
        if (psum < PAN_CENTER) begin
            pan1_next = 7'd0;
        end else if (poff > PAN_MAX) begin
            pan1_next = PAN_MAX[6:0];
        end else begin
            pan1_next = poff[6:0];
        end
        diff = in_end - in_now;
        rem1_next = diff[31] ? gain_change_time_reg : diff[30:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            tv1_reg     <= 15'(in_trem * in_vel);
            sc1_reg     <= 16'(in_svol * in_cvol);
            eg1_reg     <= in_eg;
            fade1_reg   <= in_fade;
            mixsum1_reg <= mixsum1_next;
            flag1_reg   <= in_fx[7];
            pan1_reg    <= pan1_next;
            rem1_reg    <= rem1_next;
        end
    end

    // stage 2: envelope gain and master volume products, mix scale and clamp
    logic [23:0] a2_reg;
    logic [16:0] b2_reg;
    logic [7:0]  fade2_reg;
    logic [6:0]  mix2_reg;
    logic        flag2_reg;
    logic [6:0]  pan2_reg;
    logic [30:0] rem2_reg;

    logic [29:0] a2_full;
    logic [30:0] b2_full;
    logic [23:0] mixprod;
    logic [6:0]  mix2_next;

    always_comb begin
        a2_full   = 30'(tv1_reg * eg1_reg);
        b2_full   = 31'(sc1_reg * master_volume_reg);
        mixprod   = 24'(mixsum1_reg * fx_mix_scale_reg);
        mix2_next = (mixprod > 24'(MIX_MAX)) ? MIX_MAX : mixprod[6:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            a2_reg    <= a2_full[29:6];
            b2_reg    <= b2_full[30:14];
            fade2_reg <= fade1_reg;
            mix2_reg  <= mix2_next;
            flag2_reg <= flag1_reg;
            pan2_reg  <= pan1_reg;
            rem2_reg  <= rem1_reg;
        end
    end

    // stage 3: fade scale
    logic [23:0] a3_reg;
    logic [16:0] b3_reg;
    logic [6:0]  mix3_reg;
    logic        flag3_reg;
    logic [6:0]  pan3_reg;
    logic [30:0] rem3_reg;

    logic [24:0] fprod;
    logic [16:0] b3_next;

    always_comb begin
        fprod   = 25'(fade2_reg * b2_reg) + 25'd1;
        b3_next = (fade2_reg == FADE_NONE) ? b2_reg : fprod[24:8];
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            a3_reg    <= a2_reg;
            b3_reg    <= b3_next;
            mix3_reg  <= mix2_reg;
            flag3_reg <= flag2_reg;
            pan3_reg  <= pan2_reg;
            rem3_reg  <= rem2_reg;
        end
    end

    // stage 4: final volume product, output register
    logic [15:0] vol4_reg;
    logic [6:0]  mix4_reg;
    logic        flag4_reg;
    logic [6:0]  pan4_reg;
    logic [30:0] rem4_reg;

    logic [40:0] vprod;

    assign vprod = 41'(a3_reg * b3_reg);

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            vol4_reg  <= vprod[30:15];
            mix4_reg  <= mix3_reg;
            flag4_reg <= flag3_reg;
            pan4_reg  <= pan3_reg;
            rem4_reg  <= rem3_reg;
        end
    end

    assign m_tdata = {2'b00, rem4_reg, pan4_reg, flag4_reg, mix4_reg, vol4_reg};

endmodule
`default_nettype wire
